>>> rtl/core/tmd_pkg.sv
// Types and constants shared by the track mark detector core.
// No dependencies; imported by tmd_eval and track_mark_detector_core.
package tmd_pkg;

  localparam int THR_W  = 10;
  localparam int POS_W  = 32;
  localparam int CNT_W  = 8;
  localparam int EV_W   = 3;

  // configuration register indexes
  localparam logic CFG_LINE_THR  = 1'b0;
  localparam logic CFG_CLEAR_THR = 1'b1;

  localparam logic [THR_W-1:0] LINE_THR_RST  = 10'd200;
  localparam logic [THR_W-1:0] CLEAR_THR_RST = 10'd800;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 3'd0,
    EV_LEFT  = 3'd1,
    EV_START = 3'd2,
    EV_CROSS = 3'd3,
    EV_RIGHT = 3'd4,
    EV_REARM = 3'd5
  } event_t;

  typedef struct packed {
    logic                    command;
    logic [THR_W-1:0]        left_outer;
    logic [THR_W-1:0]        left_inner;
    logic [THR_W-1:0]        right_inner;
    logic [THR_W-1:0]        right_outer;
    logic signed [POS_W-1:0] encoder_position;
  } sample_t;

  typedef struct packed {
    logic             left_latched;
    logic             right_latched;
    logic             crossing_latched;
    logic             awaiting_start;
    logic [CNT_W-1:0] mark_count;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
  } tmd_state_t;

  localparam tmd_state_t STATE_RST = '{
    left_latched:     1'b0,
    right_latched:    1'b0,
    crossing_latched: 1'b0,
    awaiting_start:   1'b1,
    mark_count:       '0,
    left_count:       '0,
    right_count:      '0
  };

  typedef struct packed {
    event_t                  event_res;
    logic                    record_valid;
    logic signed [POS_W-1:0] record_position;
    logic                    encoder_zero;
    logic [CNT_W-1:0]        mark_total;
    logic [CNT_W-1:0]        left_total;
    logic [CNT_W-1:0]        right_total;
  } result_t;

endpackage

>>> rtl/core/track_mark_detector_core.sv
// Top level of the track mark detector: input register, classifier and
// result register with stream handshakes. Depends on tmd_pkg and tmd_eval.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tuser command, in_tdata readings+pos
//  out_    | out | out_tvalid / out_tready| out_tuser event, out_tdata record+totals
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// One request per cycle sustained while out_tready stays high; a request
// passes the input register, then the result register, whose valid bit
// drives out_tvalid. The detector state advances as a request leaves the
// input register, so consecutive samples see each other's updates with no
// bubble.
// Synchronous active-low reset clears both stage valids, the detector state and
// loads the default thresholds. Back-pressure on out_tready stalls the
// result register first, then the input register; cfg_ready is always high.
module track_mark_detector_core
  import tmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] left_outer, [19:10] left_inner, [29:20] right_inner,
  // [39:30] right_outer, [71:40] encoder_position
  input  logic [71:0] in_tdata,
  // [0] command
  input  logic        in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] record_valid, [32:1] record_position, [33] encoder_zero,
  // [41:34] mark_total, [49:42] left_total, [57:50] right_total, [63:58] zero
  output logic [63:0] out_tdata,
  // [2:0] event_res
  output logic [2:0]  out_tuser,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  // stage registers
  logic             s1_valid_r;
  sample_t          s1_sample_r;
  logic             out_valid_r;
  result_t          out_res_r;

  tmd_state_t       state_r;
  tmd_state_t       state_nxt;
  result_t          res_nxt;

  logic [THR_W-1:0] line_thr_r;
  logic [THR_W-1:0] clear_thr_r;

  logic             out_free;
  logic             s1_move;
  logic             in_take;

  // result register takes a new request when empty or being drained
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  tmd_eval u_eval (
    .sample    (s1_sample_r),
    .state     (state_r),
    .line_thr  (line_thr_r),
    .clear_thr (clear_thr_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  // control and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RST;
      line_thr_r  <= LINE_THR_RST;
      clear_thr_r <= CLEAR_THR_RST;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LINE_THR:  line_thr_r  <= cfg_data;
          CFG_CLEAR_THR: clear_thr_r <= cfg_data;
          default:       line_thr_r  <= line_thr_r;
        endcase
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r.command          <= in_tuser;
      s1_sample_r.left_outer       <= in_tdata[9:0];
      s1_sample_r.left_inner       <= in_tdata[19:10];
      s1_sample_r.right_inner      <= in_tdata[29:20];
      s1_sample_r.right_outer      <= in_tdata[39:30];
      s1_sample_r.encoder_position <= in_tdata[71:40];
    end
    if (s1_move) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.event_res;
  assign out_tdata  = {6'd0,
                       out_res_r.right_total,
                       out_res_r.left_total,
                       out_res_r.mark_total,
                       out_res_r.encoder_zero,
                       out_res_r.record_position,
                       out_res_r.record_valid};

endmodule

>>> rtl/core/tmd_eval.sv
// Per-sample mark classification: threshold compares, priority rules,
// next detector state and the result. Depends on tmd_pkg.
module tmd_eval
  import tmd_pkg::*;
(
  input  sample_t          sample,
  input  tmd_state_t       state,
  input  logic [THR_W-1:0] line_thr,
  input  logic [THR_W-1:0] clear_thr,
  output tmd_state_t       state_nxt,
  output result_t          res
);

  logic see_l, see_r, clr_l, clr_r;

  assign see_l = (sample.left_outer  < line_thr) || (sample.left_inner  < line_thr);
  assign see_r = (sample.right_inner < line_thr) || (sample.right_outer < line_thr);
  assign clr_l = (sample.left_outer  > clear_thr) && (sample.left_inner  > clear_thr);
  assign clr_r = (sample.right_inner > clear_thr) && (sample.right_outer > clear_thr);

  always_comb begin
    state_nxt           = state;
    res.event_res       = EV_NONE;
    res.record_valid    = 1'b0;
    res.record_position = '0;
    res.encoder_zero    = 1'b0;

    if (sample.command) begin
      state_nxt = STATE_RST;
    end else begin
      priority if (see_l && clr_r && !state.left_latched) begin
        state_nxt.mark_count   = state.mark_count + 1'b1;
        state_nxt.left_count   = state.left_count + 1'b1;
        state_nxt.left_latched = 1'b1;
        res.event_res          = EV_LEFT;
        res.record_valid       = 1'b1;
        res.record_position    = sample.encoder_position;
      end else if (clr_l && see_r && !state.right_latched && state.awaiting_start) begin
        state_nxt.right_count    = state.right_count + 1'b1;
        state_nxt.right_latched  = 1'b1;
        state_nxt.awaiting_start = 1'b0;
        res.event_res            = EV_START;
        res.record_valid         = 1'b1;
        res.encoder_zero         = 1'b1;
      end else if (see_l && see_r && !state.crossing_latched) begin
        state_nxt.crossing_latched = 1'b1;
        state_nxt.right_latched    = 1'b1;
        state_nxt.left_latched     = 1'b1;
        res.event_res              = EV_CROSS;
      end else if (clr_l && see_r && !state.right_latched && !state.awaiting_start) begin
        // later right marks count but leave the right latch alone
        state_nxt.right_count = state.right_count + 1'b1;
        state_nxt.mark_count  = state.mark_count + 1'b1;
        res.event_res         = EV_RIGHT;
        res.record_valid      = 1'b1;
        res.record_position   = sample.encoder_position;
      end else if (clr_l && clr_r) begin
        state_nxt.crossing_latched = 1'b0;
        state_nxt.right_latched    = 1'b0;
        state_nxt.left_latched     = 1'b0;
        res.event_res              = EV_REARM;
      end else begin
        res.event_res = EV_NONE;
      end
    end

    res.mark_total  = state_nxt.mark_count;
    res.left_total  = state_nxt.left_count;
    res.right_total = state_nxt.right_count;
  end

endmodule

>>> tb/track_mark_detector_core_tb.sv
// Self-checking testbench for track_mark_detector_core: directed and random
// sensor samples with an in-order predictor. Depends on tmd_pkg and the core.
module track_mark_detector_core_tb;
  import tmd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;   // two pipeline stages plus margin
  localparam logic [9:0] RD_MAX = 10'd1023;

  // kinds of generated sample
  typedef enum logic [2:0] {
    SK_CLEAR, SK_LEFT, SK_RIGHT, SK_CROSS, SK_NOISE, SK_RESTART
  } sample_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_LINE_THR;
  logic [9:0]  cfg_data = '0;

  // predictor copy of the detector state and thresholds
  tmd_state_t       track = STATE_RST;
  logic [THR_W-1:0] line_thr = LINE_THR_RST;
  logic [THR_W-1:0] clear_thr = CLEAR_THR_RST;

  result_t pending_results[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      send_gap_pct = 19;
  int      recv_gap_pct = 69;
  int      stall_left = 0;

  track_mark_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block stops handing back requests.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side back-pressure. A long hold-off counts down here first;
  // otherwise tready drops at random per the current gap percentage.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Predicts one result and advances the predictor state. Priority order of
  // the rules matters: with overlapping thresholds a side may both see the
  // line and be clear, and the first matching rule wins.
  function automatic result_t classify_sample(input sample_t s);
    result_t r;
    logic    see_l, see_r, clr_l, clr_r;
    r = '0;
    r.event_res = EV_NONE;
    if (s.command) begin
      track = STATE_RST;  // restart: thresholds stay as written
    end else begin
      see_l = (s.left_outer < line_thr) || (s.left_inner < line_thr);
      see_r = (s.right_inner < line_thr) || (s.right_outer < line_thr);
      clr_l = (s.left_outer > clear_thr) && (s.left_inner > clear_thr);
      clr_r = (s.right_inner > clear_thr) && (s.right_outer > clear_thr);
      if (see_l && clr_r && !track.left_latched) begin
        track.mark_count   = track.mark_count + 1'b1;
        track.left_count   = track.left_count + 1'b1;
        track.left_latched = 1'b1;
        r.event_res        = EV_LEFT;
        r.record_valid     = 1'b1;
        r.record_position  = s.encoder_position;
      end else if (clr_l && see_r && !track.right_latched && track.awaiting_start) begin
        // first right mark starts the track: position recorded as zero
        track.right_count    = track.right_count + 1'b1;
        track.right_latched  = 1'b1;
        track.awaiting_start = 1'b0;
        r.event_res          = EV_START;
        r.record_valid       = 1'b1;
        r.encoder_zero       = 1'b1;
      end else if (see_l && see_r && !track.crossing_latched) begin
        track.crossing_latched = 1'b1;
        track.right_latched    = 1'b1;
        track.left_latched     = 1'b1;
        r.event_res            = EV_CROSS;
      end else if (clr_l && see_r && !track.right_latched && !track.awaiting_start) begin
        track.right_count = track.right_count + 1'b1;
        track.mark_count  = track.mark_count + 1'b1;
        r.event_res       = EV_RIGHT;
        r.record_valid    = 1'b1;
        r.record_position = s.encoder_position;
      end else if (clr_l && clr_r) begin
        // rearm fires even when nothing was latched
        track.crossing_latched = 1'b0;
        track.right_latched    = 1'b0;
        track.left_latched     = 1'b0;
        r.event_res            = EV_REARM;
      end
    end
    r.mark_total  = track.mark_count;
    r.left_total  = track.left_count;
    r.right_total = track.right_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Result checker: every accepted result is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual tuser %0h tdata %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.event_res)
          report_mismatch("event_res", want.event_res, out_tuser);
        if (out_tdata[0] !== want.record_valid)
          report_mismatch("record_valid", want.record_valid, out_tdata[0]);
        if (out_tdata[32:1] !== want.record_position)
          report_mismatch("record_position", want.record_position, out_tdata[32:1]);
        if (out_tdata[33] !== want.encoder_zero)
          report_mismatch("encoder_zero", want.encoder_zero, out_tdata[33]);
        if (out_tdata[41:34] !== want.mark_total)
          report_mismatch("mark_total", want.mark_total, out_tdata[41:34]);
        if (out_tdata[49:42] !== want.left_total)
          report_mismatch("left_total", want.left_total, out_tdata[49:42]);
        if (out_tdata[57:50] !== want.right_total)
          report_mismatch("right_total", want.right_total, out_tdata[57:50]);
      end
    end
  end

  // Offers one request after a random gap, waits for acceptance and
  // queues its prediction. tvalid is left high so back-to-back requests
  // need no extra assignment.
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.command;
    in_tdata  <= {s.encoder_position, s.right_outer, s.right_inner,
                  s.left_inner, s.left_outer};
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), classify_sample(s));
  endtask

  // Stop offering and wait until every outstanding request has come back.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    drain;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LINE_THR) line_thr = val;
    else                     clear_thr = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [9:0] line_val, input logic [9:0] clear_val);
    write_reg(CFG_LINE_THR, line_val);
    write_reg(CFG_CLEAR_THR, clear_val);
  endtask

  function automatic sample_t make_sample(input logic cmd, input logic [9:0] lo,
                                          input logic [9:0] li, input logic [9:0] ri,
                                          input logic [9:0] ro, input logic [31:0] pos);
    sample_t s;
    s.command          = cmd;
    s.left_outer       = lo;
    s.left_inner       = li;
    s.right_inner      = ri;
    s.right_outer      = ro;
    s.encoder_position = pos;
    return s;
  endfunction

  // A reading under the line threshold; random when no such value exists.
  function automatic logic [9:0] line_reading;
    if (line_thr == 0) return 10'($urandom_range(1023, 0));
    return 10'($urandom_range(line_thr - 1, 0));
  endfunction

  function automatic logic [9:0] clear_reading;
    if (clear_thr == RD_MAX) return 10'($urandom_range(1023, 0));
    return 10'($urandom_range(1023, clear_thr + 1));
  endfunction

  // One seeing side: a random sensor of the pair is on the line.
  function automatic logic [19:0] seeing_pair;
    logic [9:0] other;
    other = ($urandom_range(1) != 0) ? clear_reading() : 10'($urandom_range(1023, 0));
    if ($urandom_range(1) != 0) return {other, line_reading()};
    return {line_reading(), other};
  endfunction

  function automatic sample_t random_sample(input sample_kind_t kind);
    logic [19:0] lp, rp;
    logic [31:0] pos;
    pos = $urandom;
    lp  = {clear_reading(), clear_reading()};
    rp  = {clear_reading(), clear_reading()};
    case (kind)
      SK_LEFT:  lp = seeing_pair();
      SK_RIGHT: rp = seeing_pair();
      SK_CROSS: begin
        lp = seeing_pair();
        rp = seeing_pair();
      end
      SK_NOISE, SK_RESTART: begin
        lp = 20'($urandom);
        rp = 20'($urandom);
      end
      default: ;
    endcase
    return make_sample(kind == SK_RESTART, lp[9:0], lp[19:10], rp[9:0], rp[19:10], pos);
  endfunction

  // Mostly well-formed passages (a mark held for a few samples, then clear
  // track) with some noise and the odd restart mixed in.
  task automatic run_random_items(input int count);
    int           sent;
    int           roll;
    sample_kind_t mark;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        send_sample(random_sample(SK_RESTART));
        sent++;
      end else if (roll < 22) begin
        send_sample(random_sample(SK_NOISE));
        sent++;
      end else begin
        case ($urandom_range(3))
          0:       mark = SK_LEFT;
          1:       mark = SK_CROSS;
          default: mark = SK_RIGHT;
        endcase
        repeat ($urandom_range(3, 1)) begin
          send_sample(random_sample(mark));
          sent++;
        end
        repeat ($urandom_range(2, 1)) begin
          send_sample(random_sample(SK_CLEAR));
          sent++;
        end
      end
    end
  endtask

  // Every rule, threshold boundaries, position extremes and restart, at the
  // reset thresholds of 200 and 800.
  task automatic test_directed_rules;
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, RD_MAX, RD_MAX, 32'h0));  // rearm, idle
    send_sample(make_sample(1'b0, 10'd500, 10'd500, 10'd500, 10'd500, 32'h1)); // nothing
    send_sample(make_sample(1'b0, 10'd0, RD_MAX, RD_MAX, RD_MAX, 32'h7FFFFFFF)); // left mark
    send_sample(make_sample(1'b0, 10'd0, RD_MAX, RD_MAX, RD_MAX, 32'h5));      // latched
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, RD_MAX, RD_MAX, 32'h0));
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, 10'd0, RD_MAX, 32'h80000000)); // start
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, RD_MAX, RD_MAX, 32'h0));
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, RD_MAX, 10'd199, 32'd12345)); // right mark
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, RD_MAX, RD_MAX, 32'h0));
    send_sample(make_sample(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 32'hDEADBEEF)); // intersection
    send_sample(make_sample(1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 32'h1));
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, 10'd0, 10'd0, 32'h2)); // blocked by crossing
    send_sample(make_sample(1'b0, 10'd801, 10'd801, 10'd801, 10'd801, 32'h0)); // just above clear
    send_sample(make_sample(1'b0, RD_MAX, 10'd199, RD_MAX, RD_MAX, 32'h3)); // inner left
    send_sample(make_sample(1'b0, 10'd200, RD_MAX, 10'd800, RD_MAX, 32'h4)); // on both edges
    send_sample(make_sample(1'b0, 10'd801, 10'd801, 10'd801, 10'd801, 32'h0));
    send_sample(make_sample(1'b1, 10'd0, 10'd0, 10'd0, 10'd0, 32'hFFFFFFFF)); // restart
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, RD_MAX, 10'd0, 32'h55AA55AA)); // start again
    send_sample(make_sample(1'b0, RD_MAX, RD_MAX, RD_MAX, RD_MAX, 32'h0));
    send_sample(make_sample(1'b0, 10'd0, 10'd0, RD_MAX, RD_MAX, 32'hFFFFFFFF));
    send_sample(make_sample(1'b1, RD_MAX, RD_MAX, RD_MAX, RD_MAX, 32'hAAAAAAAA));
  endtask

  // Threshold extremes, including overlapping settings where a side both
  // sees the line and is clear.
  task automatic test_threshold_extremes;
    set_thresholds(10'd0, RD_MAX);     // nothing sees, nothing clear
    run_random_items(35);
    set_thresholds(RD_MAX, 10'd0);     // full overlap
    run_random_items(35);
    set_thresholds(10'd0, 10'd0);
    run_random_items(35);
    set_thresholds(RD_MAX, RD_MAX);
    run_random_items(35);
    set_thresholds(10'($urandom_range(1023)), 10'($urandom_range(1023)));
    run_random_items(35);
  endtask

  // Enough left passages to wrap the 8-bit left and mark counters.
  task automatic test_counter_wrap;
    set_thresholds(LINE_THR_RST, CLEAR_THR_RST);
    send_sample(random_sample(SK_RESTART));
    repeat (270) begin
      send_sample(random_sample(SK_LEFT));
      send_sample(random_sample(SK_CLEAR));
    end
  endtask

  task automatic test_random_thresholds;
    set_thresholds(10'($urandom_range(400, 150)), 10'($urandom_range(950, 600)));
    run_random_items(500);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so
  // the pipeline fills and in_tready drops; then free-running traffic.
  task automatic test_backpressure;
    set_thresholds(LINE_THR_RST, CLEAR_THR_RST);
    @(posedge clk);
    stall_left = 300;
    run_random_items(60);
    run_random_items(440);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_gap_pct = 19;
    recv_gap_pct = 69;
    test_directed_rules;
    test_threshold_extremes;
    test_counter_wrap;

    send_gap_pct = 69;
    recv_gap_pct = 19;
    test_random_thresholds;

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_backpressure;

    drain;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
